// ===== hw/rtl/tustin_pi_controller_multichannel_unit_defines.svh =====
// Assertion macros for the multichannel PI controller.
// Both macros sample on clk and are disabled while rst is high.
`ifndef TUSTIN_PI_CONTROLLER_MULTICHANNEL_UNIT_DEFINES_SVH
`define TUSTIN_PI_CONTROLLER_MULTICHANNEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TPIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpic check failed");

// Consequent must hold in the cycle after the antecedent.
`define TPIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpic check failed");

`else

`define TPIC_ASSERT_NOW(lbl, ante, cons)
`define TPIC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/tpic_pkg.sv =====
package tpic_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CH_W   = 2;

  // Default channel count
  localparam int NUM_CHANNELS_DEF = 4;

  // Arithmetic widths
  localparam int SUM_W      = DATA_W + 1;          // error + last error
  localparam int PRODI_W    = DATA_W + SUM_W;      // integral gain * |sum|
  localparam int PRODP_W    = DATA_W + DATA_W;     // prop gain * |error|
  localparam int INC_SHIFT  = 28;                  // Q4.28 fraction bits
  localparam int PROP_SHIFT = 16;                  // Q16.16 fraction bits
  localparam int RI_W       = PRODI_W - INC_SHIFT; // rounded increment magnitude
  localparam int RP_W       = PRODP_W - PROP_SHIFT - 1;
  localparam int INC_W      = RI_W + 1;
  localparam int PROP_W     = RP_W + 1;
  localparam int ACC_W      = 50;

  // Latency of the product pipeline
  localparam int MAC_LAT = 5;

  // Register reset values
  localparam logic [DATA_W-1:0]        PROP_GAIN_RST     = 32'h0001_0000;
  localparam logic [DATA_W-1:0]        INTEGRAL_GAIN_RST = 32'h0000_0000;
  localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST    = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST     = 32'sh8000_0000;

  // Register indexes
  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEGRAL_GAIN = 2'd1,
    REG_LIMIT_HIGH    = 2'd2,
    REG_LIMIT_LOW     = 2'd3
  } tpic_reg_e;

  // Clamp codes
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } tpic_clamp_e;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] error_in;
  } tpic_in_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel_out;
    logic signed [DATA_W-1:0] drive_out;
    tpic_clamp_e              clamp_state;
  } tpic_out_t;

  // Rounded, signed products
  typedef struct packed {
    logic signed [INC_W-1:0]  inc;
    logic signed [PROP_W-1:0] prop;
  } tpic_prod_t;

  // Per-stage control tag
  typedef struct packed {
    logic            valid;
    logic            live;   // channel has state storage
    logic [CH_W-1:0] ch;
  } tpic_tag_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] tpic_sat32(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] vmax;
    logic signed [ACC_W-1:0] vmin;
    vmax = ACC_W'(LIMIT_HIGH_RST);
    vmin = ACC_W'(LIMIT_LOW_RST);
    if (v > vmax) begin
      return LIMIT_HIGH_RST;
    end else if (v < vmin) begin
      return LIMIT_LOW_RST;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/tustin_pi_controller_multichannel_unit.sv =====
// Multichannel PI controller, trapezoidal integration, back-calculation anti-windup.
// Sample channel: sample_valid / sample_stall carry {channel, error_in}; a transfer
// happens when valid is high and stall is low. Result channel: result_valid /
// result_stall carry {channel_out, drive_out, clamp_state}, one result per sample,
// in order. Configuration: cfg_write with cfg_index / cfg_data, one register per
// write, to be made only while the unit is idle; the unit itself does not enforce this.
// Pipeline: one stage to fetch the last error, five in the product pipeline, the
// last of which also fetches the integrator; sum and clamp feed the output
// register directly.
// Throughput: one sample per cycle while sample_stall is low, any channel
// sequence; same-channel state still being written by the sample ahead is
// bypassed around the last-error and integrator memories.
// A stalled result holds in the output register; samples keep flowing until the
// final stage holds one too, after which sample_stall is raised.
// Reset: registers take their defaults and every channel reads zero state; no
// clearing pass is needed, so the unit takes samples in the cycle after reset.
// Channels at or above NUM_CHANNELS compute from zero state and store nothing.
`include "tustin_pi_controller_multichannel_unit_defines.svh"

module tustin_pi_controller_multichannel_unit import tpic_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_stall,
  input  tpic_in_t    sample,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output tpic_out_t   result,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NSTG = 1 + MAC_LAT;

  // Configuration registers
  logic [DATA_W-1:0]        prop_gain;
  logic [DATA_W-1:0]        integral_gain;
  logic signed [DATA_W-1:0] limit_high;
  logic signed [DATA_W-1:0] limit_low;

  // Pipeline control
  logic                     adv;
  logic                     accept;
  tpic_tag_t                tag [1:NSTG];
  tpic_tag_t                tag_in;
  logic signed [DATA_W-1:0] err1;

  // Stage 1 signals
  logic [DATA_W-1:0]        prev_err_raw;
  logic signed [SUM_W-1:0]  sum_i;
  logic                     le_wr;

  // Final stage signals
  tpic_prod_t               prod;
  logic [DATA_W-1:0]        integ_raw;
  logic signed [ACC_W-1:0]  integ_acc;
  logic signed [ACC_W-1:0]  drive_acc;
  logic signed [ACC_W-1:0]  prop_w;
  logic signed [ACC_W-1:0]  hi_w;
  logic signed [ACC_W-1:0]  lo_w;
  logic signed [ACC_W-1:0]  integ_fin;
  logic signed [ACC_W-1:0]  drive_fin;
  logic                     over_hi;
  logic                     under_lo;
  tpic_clamp_e              clamp_fin;
  logic                     int_wr;
  logic signed [DATA_W-1:0] integ_store;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= PROP_GAIN_RST;
      integral_gain <= INTEGRAL_GAIN_RST;
      limit_high    <= LIMIT_HIGH_RST;
      limit_low     <= LIMIT_LOW_RST;
    end else if (cfg_write) begin
      case (tpic_reg_e'(cfg_index))
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_INTEGRAL_GAIN: integral_gain <= cfg_data;
        REG_LIMIT_HIGH:    limit_high    <= cfg_data;
        REG_LIMIT_LOW:     limit_low     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves unless the final stage is blocked by a held result
  assign adv          = !(result_valid && result_stall && tag[NSTG].valid);
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;

  always_comb begin
    tag_in.valid = accept;
    tag_in.live  = 32'(sample.channel) < 32'(NUM_CHANNELS);
    tag_in.ch    = sample.channel;
  end

  // Tag shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) begin
        tag[k] <= '0;
      end
    end else if (adv) begin
      tag[1] <= tag_in;
      for (int k = 2; k <= NSTG; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err1 <= sample.error_in;
    end
  end

  // Last-error memory: read on transfer, written as the sample leaves stage 1
  assign le_wr = adv && tag[1].valid && tag[1].live;

  tpic_store #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW),
    .W     (DATA_W)
  ) u_last_err (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rd_addr (AW'(sample.channel)),
    .rd_live (tag_in.live),
    .wr_en   (le_wr),
    .wr_addr (AW'(tag[1].ch)),
    .wr_data (err1),
    .rd_data (prev_err_raw)
  );

  assign sum_i = SUM_W'(err1) + SUM_W'($signed(prev_err_raw));

  // Products, rounding and sign
  tpic_mac u_mac (
    .clk           (clk),
    .en            (adv),
    .prop_gain     (prop_gain),
    .integral_gain (integral_gain),
    .sum_i         (sum_i),
    .err           (err1),
    .prod          (prod)
  );

  // Integrator memory: read as a sample enters the final stage, written as it leaves
  assign int_wr = adv && tag[NSTG].valid && tag[NSTG].live;

  tpic_store #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW),
    .W     (DATA_W)
  ) u_integ (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rd_addr (AW'(tag[NSTG-1].ch)),
    .rd_live (tag[NSTG-1].live),
    .wr_en   (int_wr),
    .wr_addr (AW'(tag[NSTG].ch)),
    .wr_data (integ_store),
    .rd_data (integ_raw)
  );

  // Final stage: accumulate and clamp; low wins if above limit_high and limit_high < limit_low
  always_comb begin
    prop_w    = ACC_W'(prod.prop);
    hi_w      = ACC_W'(limit_high);
    lo_w      = ACC_W'(limit_low);
    integ_acc = ACC_W'($signed(integ_raw)) + ACC_W'(prod.inc);
    drive_acc = integ_acc + prop_w;
    over_hi   = drive_acc > hi_w;
    under_lo  = over_hi ? (limit_high < limit_low) : (drive_acc < lo_w);
    if (under_lo) begin
      drive_fin = lo_w;
      integ_fin = lo_w - prop_w;
      clamp_fin = CLAMP_LOW;
    end else if (over_hi) begin
      drive_fin = hi_w;
      integ_fin = hi_w - prop_w;
      clamp_fin = CLAMP_HIGH;
    end else begin
      drive_fin = drive_acc;
      integ_fin = integ_acc;
      clamp_fin = CLAMP_NONE;
    end
    integ_store = tpic_sat32(integ_fin);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= tag[NSTG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result.channel_out <= tag[NSTG].ch;
      result.drive_out   <= tpic_sat32(drive_fin);
      result.clamp_state <= clamp_fin;
    end
  end

  // Checks
  `TPIC_ASSERT_NOW(a_clamp_high,
                   result_valid && (result.clamp_state == CLAMP_HIGH),
                   result.drive_out == limit_high)
  `TPIC_ASSERT_NOW(a_clamp_low,
                   result_valid && (result.clamp_state == CLAMP_LOW),
                   result.drive_out == limit_low)
  `TPIC_ASSERT_NOW(a_in_limits,
                   result_valid && (result.clamp_state == CLAMP_NONE),
                   (result.drive_out <= limit_high) && (result.drive_out >= limit_low))
  `TPIC_ASSERT_NEXT(a_hold_result, result_valid && result_stall, result_valid)

endmodule

// ===== hw/rtl/tpic_ram.sv =====
module tpic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tpic_store.sv =====
module tpic_store import tpic_pkg::*; #(
  parameter int DEPTH = NUM_CHANNELS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int W     = DATA_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,       // read strobe, pipeline advance
  input  logic [AW-1:0] rd_addr,
  input  logic          rd_live,  // entry exists; otherwise reads zero
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0]     ram_q;
  logic [DEPTH-1:0] vbits;
  logic             vbit_q;
  logic             live_q;
  logic             fwd_hit_q;
  logic [W-1:0]     fwd_data_q;

  tpic_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Written-entry flags; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr_en) begin
      vbits[wr_addr] <= 1'b1;
    end
  end

  // Read-side control, plus bypass of a write to the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit_q    <= 1'b0;
      live_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (en) begin
      vbit_q    <= vbits[rd_addr];
      live_q    <= rd_live;
      fwd_hit_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    if (!live_q) begin
      rd_data = '0;
    end else if (fwd_hit_q) begin
      rd_data = fwd_data_q;
    end else if (vbit_q) begin
      rd_data = ram_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== hw/rtl/tpic_mac.sv =====
module tpic_mac import tpic_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DATA_W-1:0]        prop_gain,
  input  logic [DATA_W-1:0]        integral_gain,
  input  logic signed [SUM_W-1:0]  sum_i,   // error + last error
  input  logic signed [DATA_W-1:0] err,
  output tpic_prod_t               prod
);

  // Stage a: capture operands
  logic signed [SUM_W-1:0]  sa_i;
  logic signed [DATA_W-1:0] sa_p;
  // Stage b: sign and magnitude
  logic                     neg_i_b, neg_p_b;
  logic [SUM_W-1:0]         mag_i;
  logic [DATA_W-1:0]        mag_p;
  // Stage c: products
  logic                     neg_i_c, neg_p_c;
  logic [PRODI_W-1:0]       prod_i;
  logic [PRODP_W-1:0]       prod_p;
  // Stage d: rounded magnitudes
  logic                     neg_i_d, neg_p_d;
  logic [RI_W-1:0]          r_i;
  logic [RP_W-1:0]          r_p;
  logic [PRODI_W-1:0]       rnd_i;
  logic [PRODP_W-1:0]       rnd_p;

  // Round half away from zero on the magnitude
  assign rnd_i = prod_i + (PRODI_W'(1) << (INC_SHIFT - 1));
  assign rnd_p = prod_p + (PRODP_W'(1) << (PROP_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      sa_i    <= sum_i;
      sa_p    <= err;

      neg_i_b <= sa_i[SUM_W-1];
      neg_p_b <= sa_p[DATA_W-1];
      mag_i   <= sa_i[SUM_W-1] ? SUM_W'(-sa_i) : SUM_W'(sa_i);
      mag_p   <= sa_p[DATA_W-1] ? DATA_W'(-sa_p) : DATA_W'(sa_p);

      neg_i_c <= neg_i_b;
      neg_p_c <= neg_p_b;
      prod_i  <= PRODI_W'(integral_gain) * PRODI_W'(mag_i);
      prod_p  <= PRODP_W'(prop_gain) * PRODP_W'(mag_p);

      neg_i_d <= neg_i_c;
      neg_p_d <= neg_p_c;
      r_i     <= rnd_i[INC_SHIFT +: RI_W];
      r_p     <= rnd_p[PROP_SHIFT +: RP_W];

      prod.inc  <= neg_i_d ? -$signed({1'b0, r_i}) : $signed({1'b0, r_i});
      prod.prop <= neg_p_d ? -$signed({1'b0, r_p}) : $signed({1'b0, r_p});
    end
  end

endmodule
